>>> hw/rtl/smpl_pkg.sv
// Shared constants and types for the scan motor position loop.
`timescale 1ns / 1ps

package smpl_pkg;

  // Parameter defaults
  localparam int ANGLE_BITS_DEF  = 18;
  localparam int ERROR_CLAMP_DEF = 65536;

  // Fixed field widths
  localparam int RAW_W      = 18;
  localparam int TENTHS_W   = 12;
  localparam int DRIVE_W    = 16;
  localparam int POS_LOW_W  = 32;
  localparam int TURN_W     = 32;
  localparam int DB_W       = 18;
  localparam int SPAN_W     = 18;
  localparam int GAIN_W     = 24;
  localparam int GAIN_FRAC  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_PAD_W   = 3;
  localparam int OUT_TDATA_W = TENTHS_W + 2 * DRIVE_W + POS_LOW_W + 1 + OUT_PAD_W;

  // Tenths of a degree in a full turn and in half a turn
  localparam int DEG_TENTHS  = 3600;
  localparam logic signed [TENTHS_W-1:0] TENTHS_HALF = 12'sd1800;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd4;

  // Configuration register set
  typedef struct packed {
    logic [DB_W-1:0]    deadband;
    logic [SPAN_W-1:0]  half_span;
    logic [GAIN_W-1:0]  gain;
    logic [DRIVE_W-1:0] drive_min;
    logic [DRIVE_W-1:0] drive_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    deadband:  18'd100,
    half_span: 18'd65536,
    gain:      24'd65536,
    drive_min: 16'd0,
    drive_max: 16'd999
  };

  // Decisions handed from the tracking stage to the drive stage
  typedef struct packed {
    logic fwd;
    logic rev;
    logic heading;
  } trk_flags_t;

endpackage

>>> hw/rtl/smpl_track.sv
// Turn counting, homing, error and scan direction stage of the position loop.
`timescale 1ns / 1ps

module smpl_track
  import smpl_pkg::*;
#(
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
  parameter int ERROR_CLAMP = ERROR_CLAMP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ANGLE_BITS-1:0] in_angle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output trk_flags_t            out_flags,
  output logic [ANGLE_BITS-1:0] out_rel,
  output logic [$clog2(ERROR_CLAMP+1)-1:0] out_mag,
  output logic [POS_LOW_W-1:0]  out_pos_low
);

  localparam int CLAMP_W = $clog2(ERROR_CLAMP + 1);
  localparam int POS_W   = TURN_W + ANGLE_BITS;
  localparam int TGT_W   = POS_W + 1;
  localparam int ERR_W   = POS_W + 2;
  localparam logic signed [ANGLE_BITS:0] HALF_S = {2'b01, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [ERR_W-1:0] CLAMP_E = ERR_W'(ERROR_CLAMP);

  // Tracking state
  logic [ANGLE_BITS-1:0] prev_r;
  logic [TURN_W-1:0]     turn_r, turn_nxt;
  logic [POS_W-1:0]      home_r, home_nxt;
  logic [TGT_W-1:0]      target_r, target_nxt;
  logic                  head_r, head_nxt;
  logic                  homed_r;
  logic                  valid_r;

  logic                         fire;
  logic signed [ANGLE_BITS:0]   diff;
  logic [POS_W-1:0]             pos;
  logic signed [ERR_W-1:0]      pos_e, target_e, db_e, neg_db, err, mag_full;
  logic signed [TGT_W-1:0]      home_t, span_t;
  logic                         fwd, rev;
  logic [CLAMP_W-1:0]           mag;

  assign in_ready = !valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  // Turn counting on a step of more than half a turn
  assign diff = $signed({1'b0, in_angle}) - $signed({1'b0, prev_r});

  always_comb begin
    turn_nxt = turn_r;
    if (homed_r && (diff < -HALF_S)) begin
      turn_nxt = turn_r + TURN_W'(1);
    end else if (homed_r && (diff > HALF_S)) begin
      turn_nxt = turn_r - TURN_W'(1);
    end
  end

  // Absolute position and error against the target
  assign pos      = {turn_nxt, in_angle};
  assign pos_e    = {{2{pos[POS_W-1]}}, pos};
  assign target_e = {target_r[TGT_W-1], target_r};
  assign home_t   = {home_r[POS_W-1], home_r};
  assign span_t   = {{(TGT_W-SPAN_W){1'b0}}, cfg.half_span};
  assign db_e     = {{(ERR_W-DB_W){1'b0}}, cfg.deadband};
  assign neg_db   = -db_e;
  assign err      = target_e - pos_e;

  assign fwd      = err > db_e;
  assign rev      = err < neg_db;
  assign mag_full = fwd ? err : -err;
  assign mag      = (mag_full > CLAMP_E) ? CLAMP_W'(ERROR_CLAMP) : mag_full[CLAMP_W-1:0];

  // Homing on the first item, scan reversal at each end afterwards
  always_comb begin
    home_nxt   = home_r;
    target_nxt = target_r;
    head_nxt   = head_r;
    if (!homed_r) begin
      home_nxt   = pos;
      target_nxt = $signed({pos[POS_W-1], pos}) - span_t;
      head_nxt   = 1'b0;
    end else if (head_r && (err < db_e)) begin
      head_nxt   = 1'b0;
      target_nxt = home_t - span_t;
    end else if (!head_r && (err > neg_db)) begin
      head_nxt   = 1'b1;
      target_nxt = home_t + span_t;
    end
  end

  // State registers, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      turn_r   <= '0;
      home_r   <= '0;
      target_r <= '0;
      head_r   <= 1'b0;
      homed_r  <= 1'b0;
    end else if (fire) begin
      prev_r   <= in_angle;
      turn_r   <= turn_nxt;
      home_r   <= home_nxt;
      target_r <= target_nxt;
      head_r   <= head_nxt;
      homed_r  <= 1'b1;
    end
  end

  // Stage register toward the drive stage; the homing item leaves no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= fire && homed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_flags.fwd     <= fwd;
      out_flags.rev     <= rev;
      out_flags.heading <= head_nxt;
      out_rel           <= in_angle - home_r[ANGLE_BITS-1:0];
      out_mag           <= mag;
      out_pos_low       <= pos[POS_LOW_W-1:0];
    end
  end

  assign out_valid = valid_r;

  // Once homed, the block stays homed until reset
  a_homed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(homed_r) && $past(rst_n)) |-> homed_r)
    else $error("homed flag dropped without reset");

  // A result only leaves this stage after homing
  a_result_after_home: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> homed_r)
    else $error("result produced before homing");

endmodule

>>> hw/rtl/smpl_drive.sv
// Angle scaling, proportional drive and output register of the position loop.
`timescale 1ns / 1ps

module smpl_drive
  import smpl_pkg::*;
#(
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
  parameter int ERROR_CLAMP = ERROR_CLAMP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  trk_flags_t            in_flags,
  input  logic [ANGLE_BITS-1:0] in_rel,
  input  logic [$clog2(ERROR_CLAMP+1)-1:0] in_mag,
  input  logic [POS_LOW_W-1:0]  in_pos_low,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TENTHS_W-1:0]   out_tenths,
  output logic [DRIVE_W-1:0]    out_fwd,
  output logic [DRIVE_W-1:0]    out_rev,
  output logic [POS_LOW_W-1:0]  out_pos_low,
  output logic                  out_heading
);

  localparam int CLAMP_W = $clog2(ERROR_CLAMP + 1);
  localparam int TPROD_W = ANGLE_BITS + TENTHS_W;
  localparam int GPROD_W = CLAMP_W + GAIN_W;
  localparam int DHI_W   = GPROD_W - GAIN_FRAC;
  localparam logic [ANGLE_BITS-1:0] HALF_U = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic                  valid_r;
  logic                  load;
  logic                  near;
  logic [ANGLE_BITS-1:0] rel_mag;
  logic [TPROD_W-1:0]    tprod;
  logic [TENTHS_W-1:0]   tmag, tenths;
  logic [GPROD_W-1:0]    gprod;
  logic [DHI_W-1:0]      dshift;
  logic [DRIVE_W-1:0]    dsat, dlim, drv;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // Angle from home to tenths of a degree, truncated toward zero
  assign near    = in_rel <= HALF_U;
  assign rel_mag = near ? in_rel : (ANGLE_BITS'(0) - in_rel);
  assign tprod   = {{TENTHS_W{1'b0}}, rel_mag} * TPROD_W'(DEG_TENTHS);
  assign tmag    = tprod[TPROD_W-1:ANGLE_BITS];
  assign tenths  = near ? tmag : (TENTHS_W'(0) - tmag);

  // Gain times clamped error, then saturation and drive limits
  assign gprod  = {{CLAMP_W{1'b0}}, cfg.gain} * {{GAIN_W{1'b0}}, in_mag};
  assign dshift = gprod[GPROD_W-1:GAIN_FRAC];
  assign dsat   = (|dshift[DHI_W-1:DRIVE_W]) ? {DRIVE_W{1'b1}} : dshift[DRIVE_W-1:0];
  assign dlim   = (dsat > cfg.drive_max) ? cfg.drive_max : dsat;
  assign drv    = (dlim < cfg.drive_min) ? cfg.drive_min : dlim;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tenths  <= tenths;
      out_fwd     <= in_flags.fwd ? drv : '0;
      out_rev     <= in_flags.rev ? drv : '0;
      out_pos_low <= in_pos_low;
      out_heading <= in_flags.heading;
    end
  end

  assign out_valid = valid_r;

endmodule

>>> hw/rtl/scan_motor_position_loop.sv
// Each result passes through the input, tracking and output registers after its input is accepted.
// Throughput: one transaction per cycle while the result stream is not stalled.
// The first transaction after reset only homes the loop and produces no result.
// Reset (rst_n low, synchronous) empties the pipeline, clears tracking state
// and restores all configuration registers to their defaults.
`timescale 1ns / 1ps

module scan_motor_position_loop
  import smpl_pkg::*;
#(
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
  parameter int ERROR_CLAMP = ERROR_CLAMP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [17:0] raw_angle, [23:18] zero
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] angle_tenths, [27:12] forward_drive,
                                             // [43:28] reverse_drive, [75:44] position_low,
                                             // [76] scan_heading, [79:77] zero
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CLAMP_W = $clog2(ERROR_CLAMP + 1);

  cfg_t                  cfg_r, cfg_nxt;
  logic                  s1_valid_r;
  logic [ANGLE_BITS-1:0] s1_angle_r;
  logic                  s1_ready;
  logic [RAW_W+ANGLE_BITS-1:0] raw_ext;
  logic [ANGLE_BITS-1:0] in_angle;

  logic                  trk_valid, trk_ready, trk_in_ready;
  trk_flags_t            trk_flags;
  logic [ANGLE_BITS-1:0] trk_rel;
  logic [CLAMP_W-1:0]    trk_mag;
  logic [POS_LOW_W-1:0]  trk_pos_low;

  logic [TENTHS_W-1:0]   res_tenths;
  logic [DRIVE_W-1:0]    res_fwd, res_rev;
  logic [POS_LOW_W-1:0]  res_pos_low;
  logic                  res_heading;

  // Configuration registers; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DEADBAND:  cfg_nxt.deadband  = cfg_data[DB_W-1:0];
        REG_HALF_SPAN: cfg_nxt.half_span = cfg_data[SPAN_W-1:0];
        REG_GAIN:      cfg_nxt.gain      = cfg_data[GAIN_W-1:0];
        REG_DRIVE_MIN: cfg_nxt.drive_min = cfg_data[DRIVE_W-1:0];
        REG_DRIVE_MAX: cfg_nxt.drive_max = cfg_data[DRIVE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register; angle bits above ANGLE_BITS are dropped
  assign raw_ext   = {{ANGLE_BITS{1'b0}}, in_tdata[RAW_W-1:0]};
  assign in_angle  = raw_ext[ANGLE_BITS-1:0];
  assign s1_ready  = !s1_valid_r || trk_in_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_angle_r <= in_angle;
    end
  end

  // Tracking stage
  smpl_track #(
    .ANGLE_BITS  (ANGLE_BITS),
    .ERROR_CLAMP (ERROR_CLAMP)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (s1_valid_r),
    .in_ready    (trk_in_ready),
    .in_angle    (s1_angle_r),
    .out_valid   (trk_valid),
    .out_ready   (trk_ready),
    .out_flags   (trk_flags),
    .out_rel     (trk_rel),
    .out_mag     (trk_mag),
    .out_pos_low (trk_pos_low)
  );

  // Drive stage and output register
  smpl_drive #(
    .ANGLE_BITS  (ANGLE_BITS),
    .ERROR_CLAMP (ERROR_CLAMP)
  ) u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (trk_valid),
    .in_ready    (trk_ready),
    .in_flags    (trk_flags),
    .in_rel      (trk_rel),
    .in_mag      (trk_mag),
    .in_pos_low  (trk_pos_low),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_tenths  (res_tenths),
    .out_fwd     (res_fwd),
    .out_rev     (res_rev),
    .out_pos_low (res_pos_low),
    .out_heading (res_heading)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_heading, res_pos_low, res_rev, res_fwd, res_tenths};

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Forward and reverse drive are never both active
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res_fwd == '0) || (res_rev == '0)))
    else $error("forward and reverse drive both nonzero");

  // Relative angle stays within half a turn
  a_tenths_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(res_tenths) >= -TENTHS_HALF) &&
                    ($signed(res_tenths) <= TENTHS_HALF)))
    else $error("angle in tenths out of range");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the scan motor position loop, with its own tracking predictor.
`timescale 1ns / 1ps

module testbench;
  import smpl_pkg::*;

  localparam int FULL_TURN   = 1 << ANGLE_BITS_DEF;
  localparam int HALF_TURN   = FULL_TURN / 2;
  localparam int MAX_GAP     = 12;
  localparam int LONG_HOLD   = 80;
  localparam int SETTLE      = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;

  // Bit positions of the result fields inside out_tdata
  localparam int FWD_LSB  = TENTHS_W;
  localparam int REV_LSB  = FWD_LSB + DRIVE_W;
  localparam int POS_LSB  = REV_LSB + DRIVE_W;
  localparam int HEAD_BIT = POS_LSB + POS_LOW_W;

  // Register indexes that no register answers to
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

  typedef struct {
    logic signed [TENTHS_W-1:0] tenths;
    logic [DRIVE_W-1:0]         fwd;
    logic [DRIVE_W-1:0]         rev;
    logic [POS_LOW_W-1:0]       pos_low;
    logic                       heading;
  } loop_reading_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Stimulus and scoreboard bookkeeping
  logic [RAW_W-1:0] angle_q [$];
  loop_reading_t    reading_q [$];
  logic [RAW_W-1:0] walk_angle      = '0;
  logic             in_acc          = 1'b0;
  logic             out_acc         = 1'b0;
  int               items_pushed    = 0;
  int               items_accepted  = 0;
  int               results_checked = 0;
  int               cfg_writes      = 0;
  int               mismatches      = 0;
  int               quiet_cycles    = 0;
  int               send_wait       = 0;
  int               out_wait        = 0;
  int               hold_left       = 0;
  bit               send_gaps       = 1'b1;
  bit               recv_gaps       = 1'b1;
  bit               hold_req        = 1'b0;
  bit               hold_taken      = 1'b0;

  // Predicted state of the loop and its registers
  cfg_t             trk_cfg     = CFG_RESET;
  logic [RAW_W-1:0] trk_prev    = '0;
  logic [TURN_W-1:0] trk_turns  = '0;
  longint           trk_home    = 0;
  longint           trk_target  = 0;
  bit               trk_heading = 1'b0;
  bit               trk_homed   = 1'b0;

  scan_motor_position_loop DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clamp the error, scale by the gain, then saturate and apply the drive limits.
  function automatic logic [DRIVE_W-1:0] drive_level(input longint mag);
    longint m;
    longint d;
    m = (mag > ERROR_CLAMP_DEF) ? longint'(ERROR_CLAMP_DEF) : mag;
    d = (m * longint'(trk_cfg.gain)) >>> GAIN_FRAC;
    if (d > 65535) d = 65535;
    if (d > longint'(trk_cfg.drive_max)) d = longint'(trk_cfg.drive_max);
    if (d < longint'(trk_cfg.drive_min)) d = longint'(trk_cfg.drive_min);
    return d[DRIVE_W-1:0];
  endfunction

  // Advance the predicted loop by one angle sample; returns 1 when a result is due.
  function automatic bit track_angle(input logic [RAW_W-1:0] angle, output loop_reading_t rd);
    longint diff;
    longint pos;
    longint rel;
    longint r;
    longint tenths;
    longint err;
    longint db;
    longint span;
    rd = '{default: '0};
    diff = longint'(angle) - longint'(trk_prev);
    if (trk_homed) begin
      if (diff < -HALF_TURN) trk_turns = trk_turns + 1'b1;
      else if (diff > HALF_TURN) trk_turns = trk_turns - 1'b1;
    end
    trk_prev = angle;
    pos = longint'($signed(trk_turns)) * FULL_TURN + longint'(angle);
    span = longint'(trk_cfg.half_span);

    // The first sample after reset only sets home and aims at the negative end.
    if (!trk_homed) begin
      trk_homed = 1'b1;
      trk_home = pos;
      trk_target = pos - span;
      trk_heading = 1'b0;
      return 1'b0;
    end

    // Angle from home, wrapped to half a turn either way and truncated toward zero.
    rel = pos - trk_home;
    r = rel & longint'(FULL_TURN - 1);
    if (r <= HALF_TURN) tenths = (r * DEG_TENTHS) >>> ANGLE_BITS_DEF;
    else tenths = -(((FULL_TURN - r) * DEG_TENTHS) >>> ANGLE_BITS_DEF);

    db = longint'(trk_cfg.deadband);
    err = trk_target - pos;
    if (err > db) rd.fwd = drive_level(err);
    else if (err < -db) rd.rev = drive_level(-err);

    // Reverse the scan once the current end has been reached.
    if (trk_heading && err < db) begin
      trk_heading = 1'b0;
      trk_target = trk_home - span;
    end else if (!trk_heading && err > -db) begin
      trk_heading = 1'b1;
      trk_target = trk_home + span;
    end

    rd.tenths = tenths[TENTHS_W-1:0];
    rd.pos_low = pos[POS_LOW_W-1:0];
    rd.heading = trk_heading;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Input side: offer queued angles, with a random pause after each transaction when gaps are enabled.
  always @(negedge clk) begin : sender
    logic                  nv;
    logic [IN_TDATA_W-1:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (in_acc) nv = 1'b0;
    if (rst_n && !nv) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (angle_q.size() != 0) begin
        nv = 1'b1;
        nd = '0;
        nd[RAW_W-1:0] = angle_q.pop_front();
        send_wait = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
  end

  // Result side: random stalls per transaction when gaps are enabled, plus one long hold-off on request.
  always @(negedge clk) begin : receiver
    logic nr;
    nr = 1'b0;
    if (rst_n) begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (out_acc) out_wait = recv_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (out_wait > 0) begin
        out_wait--;
      end else begin
        nr = 1'b1;
      end
    end
    out_tready <= nr;
  end

  // Sample every handshake, update the predictor and compare results.
  always @(posedge clk) begin : monitor
    loop_reading_t rd;
    loop_reading_t got;
    loop_reading_t want;
    in_acc <= rst_n && in_tvalid && in_tready;
    out_acc <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        cfg_writes++;
        case (cfg_index)
          REG_DEADBAND:  trk_cfg.deadband = cfg_data[DB_W-1:0];
          REG_HALF_SPAN: trk_cfg.half_span = cfg_data[SPAN_W-1:0];
          REG_GAIN:      trk_cfg.gain = cfg_data[GAIN_W-1:0];
          REG_DRIVE_MIN: trk_cfg.drive_min = cfg_data[DRIVE_W-1:0];
          REG_DRIVE_MAX: trk_cfg.drive_max = cfg_data[DRIVE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        quiet_cycles = 0;
        items_accepted++;
        if (track_angle(in_tdata[RAW_W-1:0], rd)) reading_q.push_back(rd);
      end
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        got.tenths = out_tdata[TENTHS_W-1:0];
        got.fwd = out_tdata[FWD_LSB +: DRIVE_W];
        got.rev = out_tdata[REV_LSB +: DRIVE_W];
        got.pos_low = out_tdata[POS_LSB +: POS_LOW_W];
        got.heading = out_tdata[HEAD_BIT];
        if (reading_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual tdata %h", $time, out_tdata);
        end else begin
          want = reading_q.pop_front();
          results_checked++;
          check_field("angle_tenths", want.tenths, got.tenths);
          check_field("forward_drive", want.fwd, got.fwd);
          check_field("reverse_drive", want.rev, got.rev);
          check_field("position_low", want.pos_low, got.pos_low);
          check_field("scan_heading", want.heading, got.heading);
        end
      end
    end
  end

  // Watchdog: too long without any transaction means the block is stuck.
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_angle(input logic [RAW_W-1:0] a);
    angle_q.push_back(a);
    items_pushed++;
  endtask

  // Mostly sweeps of steady steps in one direction, some random jumps between them.
  task automatic push_motion(input int count);
    int               left;
    int               run;
    int               span_sel;
    logic [RAW_W-1:0] step;
    bit               up;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        walk_angle = RAW_W'($urandom());
        push_angle(walk_angle);
        left--;
      end else begin
        span_sel = $urandom_range(0, 9);
        if (span_sel < 3) step = RAW_W'($urandom_range(0, 64));
        else if (span_sel < 7) step = RAW_W'($urandom_range(0, 4096));
        else if (span_sel < 9) step = RAW_W'($urandom_range(0, HALF_TURN));
        else step = RAW_W'($urandom_range(HALF_TURN + 1, FULL_TURN - 1));
        up = ($urandom_range(0, 1) == 1);
        run = $urandom_range(1, 24);
        while (run > 0 && left > 0) begin
          walk_angle = up ? walk_angle + step : walk_angle - step;
          push_angle(walk_angle);
          run--;
          left--;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] db, input logic [CFG_DATA_W-1:0] span,
                           input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] dmin,
                           input logic [CFG_DATA_W-1:0] dmax);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_HALF_SPAN, span);
    write_reg(REG_GAIN, gain);
    write_reg(REG_DRIVE_MIN, dmin);
    write_reg(REG_DRIVE_MAX, dmax);
  endtask

  // Wait until every angle is taken and every result is in, then let the pipeline drain.
  task automatic wait_idle;
    while (items_accepted != items_pushed || reading_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stimulus
    int ph;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed angles under the reset settings: homing, half-turn steps, wrap in both directions.
    @(posedge clk);
    push_angle(18'd0);
    push_angle(18'd131072);
    push_angle(18'd262143);
    push_angle(18'd0);
    push_angle(18'd131073);
    push_angle(18'd131072);
    push_angle(18'd1);
    push_angle(18'd262143);
    push_angle(18'd196608);
    push_angle(18'd196640);
    push_angle(18'd196700);
    push_angle(18'd196540);
    push_angle(18'd65536);
    push_angle(18'd65600);
    push_angle(18'd65500);
    push_angle(18'd0);
    walk_angle = '0;

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        // Zero deadband and span, largest gain and limits: the product saturates.
        0: write_all(24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'd65535);
        // Deadband and span of half a turn, no gain, drive held at zero.
        1: write_all(24'd131072, 24'd131072, 24'd0, 24'd0, 24'd0);
        // Oversized values keep their low bits, minimum above maximum, spare indexes ignored.
        2: begin
          write_all(24'hFC0064, 24'hFD0000, 24'd65536, 24'hAB1388, 24'hCD0064);
          write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
          write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
          write_reg(REG_SPARE_C, CFG_DATA_W'($urandom()));
        end
        3: write_all(24'd20, 24'd30000, 24'd196608, 24'd0, 24'd65535);
        default: write_all(
          CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3000)),
          CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 131072)),
          CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 262144)),
          CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 300)),
          CFG_DATA_W'(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 2000)));
      endcase
      @(posedge clk);
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      if (ph == 3) begin
        // Back-to-back input against a stalled receiver fills the pipeline.
        send_gaps = 1'b0;
        recv_gaps = 1'b1;
        hold_req = 1'b1;
      end else if (ph == 4) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      push_motion(PHASE_ITEMS);
    end
    wait_idle();

    $display("Covered %0d angle samples, %0d checked results, %0d register writes, %0d setups.",
             items_accepted, results_checked, cfg_writes, PHASES + 1);
    $display("Field mismatches and unexpected results: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
